>>> rtl/core/bcp_pkg.sv
// Shared types, character constants and helpers for the bracket command packet parser.
package bcp_pkg;

    // Longest packet kept, counting its closing bracket.
    localparam int MAX_PACKET = 256;
    localparam int LEN_W      = $clog2(MAX_PACKET + 1);

    localparam logic [7:0] CH_LBRACKET = 8'h5B;  // '['
    localparam logic [7:0] CH_RBRACKET = 8'h5D;  // ']'
    localparam logic [7:0] CH_LT       = 8'h3C;  // '<'
    localparam logic [7:0] CH_PLUS     = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS    = 8'h2D;  // '-'
    localparam logic [7:0] CH_T        = 8'h54;  // 'T'
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    localparam logic [3:0] HEADER_LEN = 4'd8;
    localparam logic [3:0] KEY_LEN    = 4'd6;

    // Index 0 holds the first character; key texts are padded to eight entries.
    localparam logic [0:7][7:0] HEADER_TEXT = "[COMMAND";
    localparam logic [0:7][7:0] SPEED_TEXT  = {"SPEED>", 16'h0000};
    localparam logic [0:7][7:0] STEER_TEXT  = {"STEER>", 16'h0000};

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    localparam logic TARGET_SPEED = 1'b0;
    localparam logic TARGET_STEER = 1'b1;

    typedef enum logic [6:0] {
        PH_HEADER    = 7'b000_0001,
        PH_SEEK      = 7'b000_0010,
        PH_KEY       = 7'b000_0100,
        PH_NUM_START = 7'b000_1000,
        PH_NUM_WS    = 7'b001_0000,
        PH_NUM_DIG   = 7'b010_0000,
        PH_SKIP      = 7'b100_0000
    } t_phase;

    typedef struct packed {
        logic               target;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic emit;
        t_cmd cmd;
    } t_step_res;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

>>> rtl/core/bcp_byte_if.sv
// Valid/ready channel carrying one received byte.
interface bcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/bcp_cmd_if.sv
// Valid/ready channel carrying one parsed servo command.
interface bcp_cmd_if;
    logic               valid;
    logic               ready;
    logic               target;
    logic signed [31:0] value;

    modport source (output valid, output target, output value, input ready);
    modport sink   (input valid, input target, input value, output ready);
endinterface

>>> rtl/core/bcp_in_stage.sv
// Input register holding one received byte until the parse step takes it.
module bcp_in_stage import bcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_space,
    output logic       o_fire,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_fire  = r_valid && i_space;
    assign o_ready = !r_valid || i_space;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

>>> rtl/core/bcp_step.sv
// Packet state and the per-byte parse step that yields at most one command.
module bcp_step import bcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_step_res  o_res
);

    t_phase           r_phase, n_phase;
    logic [3:0]       r_pos, n_pos;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_bad, n_bad;
    logic             r_steer, n_steer;
    logic             r_neg, n_neg;
    logic [31:0]      r_acc, n_acc;
    logic             r_done, n_done;

    logic [35:0]      w_sum;
    logic [31:0]      w_sat;
    logic             w_bad;
    logic             w_steer_sel;
    logic [7:0]       w_key_char;

    // acc * 10 + digit as two shifts and an add; saturate the magnitude at 2^31.
    assign w_sum = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {32'b0, i_byte[3:0]};
    assign w_sat = (w_sum > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : w_sum[31:0];

    // The second key character picks the key text.
    assign w_steer_sel = (r_pos == 4'd1) ? (i_byte == CH_T) : r_steer;
    assign w_key_char  = w_steer_sel ? STEER_TEXT[r_pos[2:0]] : SPEED_TEXT[r_pos[2:0]];

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_len   = r_len;
        n_bad   = r_bad;
        n_steer = r_steer;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_done  = r_done;
        w_bad   = r_bad;
        o_res   = '0;

        if (i_byte == CH_LBRACKET && r_len != '0) begin
            // Restart the packet with this bracket already matched.
            n_phase = PH_HEADER;
            n_pos   = 4'd1;
            n_len   = LEN_W'(1);
            n_bad   = 1'b0;
            n_steer = 1'b0;
            n_neg   = 1'b0;
            n_acc   = '0;
            n_done  = 1'b0;
        end else begin
            if (r_len >= LEN_W'(MAX_PACKET)) begin
                w_bad = 1'b1;
            end else begin
                n_len = r_len + LEN_W'(1);
            end
            n_bad = w_bad;

            if (i_byte == CH_RBRACKET) begin
                if (!w_bad && (r_phase == PH_NUM_WS || r_phase == PH_NUM_DIG)) begin
                    o_res.emit       = 1'b1;
                    o_res.cmd.target = r_steer ? TARGET_STEER : TARGET_SPEED;
                    if (r_neg) begin
                        o_res.cmd.value = 32'd0 - r_acc;
                    end else begin
                        o_res.cmd.value = r_acc[31] ? POS_MAX : r_acc;
                    end
                end
                n_phase = PH_HEADER;
                n_pos   = '0;
                n_len   = '0;
                n_bad   = 1'b0;
                n_steer = 1'b0;
                n_neg   = 1'b0;
                n_acc   = '0;
                n_done  = 1'b0;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_pos < HEADER_LEN && i_byte == HEADER_TEXT[r_pos[2:0]]) begin
                            if (r_pos == HEADER_LEN - 4'd1) begin
                                n_phase = PH_SEEK;
                                n_pos   = '0;
                            end else begin
                                n_pos = r_pos + 4'd1;
                            end
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SEEK: begin
                        if (i_byte == CH_LT) begin
                            n_phase = PH_KEY;
                            n_pos   = '0;
                        end
                    end
                    PH_KEY: begin
                        if (r_pos == 4'd1) begin
                            n_steer = w_steer_sel;
                        end
                        if (r_pos < KEY_LEN && i_byte == w_key_char) begin
                            n_pos = r_pos + 4'd1;
                            if (r_pos == KEY_LEN - 4'd1) begin
                                n_phase = PH_NUM_START;
                            end
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_NUM_START, PH_NUM_WS: begin
                        n_phase = PH_NUM_WS;
                        if (!is_space(i_byte)) begin
                            n_phase = PH_NUM_DIG;
                            if (i_byte == CH_PLUS || i_byte == CH_MINUS) begin
                                n_neg = (i_byte == CH_MINUS);
                            end else if (is_digit(i_byte)) begin
                                n_acc = w_sat;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                    end
                    PH_NUM_DIG: begin
                        if (!r_done && is_digit(i_byte)) begin
                            n_acc = w_sat;
                        end else begin
                            n_done = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_SKIP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_len   <= '0;
            r_bad   <= 1'b0;
            r_steer <= 1'b0;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_done  <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_bad   <= n_bad;
            r_steer <= n_steer;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_done  <= n_done;
        end
    end

    a_close_clears_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_byte == CH_RBRACKET |=> r_len == '0)
        else $error("closing bracket did not clear packet length");

    a_restart_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_byte == CH_LBRACKET && r_len != '0 |=> r_phase == PH_HEADER && r_pos == 4'd1)
        else $error("bracket restart did not reload header match");

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_PACKET))
        else $error("packet length beyond limit");

    a_acc_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= MAG_LIMIT)
        else $error("magnitude beyond saturation limit");

    a_neg_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.emit && r_neg |-> o_res.cmd.value <= 0)
        else $error("negative command with positive value");

endmodule

>>> rtl/core/bcp_out_stage.sv
// Result register holding one command until the receiver takes it.
module bcp_out_stage import bcp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_step_res i_res,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_cmd      o_cmd
);

    logic r_valid;
    t_cmd r_cmd;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_fire && i_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_fire && i_res.emit) begin
            r_cmd <= i_res.cmd;
        end
    end

endmodule

>>> rtl/core/bracket_command_packet_parser.sv
// Top level of the bracket command packet parser.
//
// Usage: received bytes enter on i_rx, one request per byte. A packet of the
// form "[COMMAND ... <SPEED>n]" or "[COMMAND ... <STEER>n]" yields one request
// on o_cmd: target 0 for the speed servo, 1 for steering, and the signed
// decimal value saturated to 32 bits. Any other packet is dropped silently.
// A '[' inside a packet restarts it; packets over 256 bytes are dropped.
// Path: a byte passes the input register, then the parse step into the result
// register, where its command waits on o_cmd until taken.
// Throughput: one byte per cycle unless a command waits on o_cmd with ready
// low, set by the combinational parse step between the two registers.
// Reset clears the parse state and empties both registers.
// While a command waits on o_cmd with ready low, the parse step holds: the next
// byte waits in the input register, and i_rx.ready drops once that register is
// full.
module bracket_command_packet_parser import bcp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bcp_byte_if.sink  i_rx,
    bcp_cmd_if.source o_cmd
);

    logic       w_space;
    logic       w_fire;
    logic [7:0] w_byte;
    t_step_res  w_res;
    t_cmd       w_cmd;

    bcp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .i_byte  (i_rx.rx_byte),
        .o_ready (i_rx.ready),
        .i_space (w_space),
        .o_fire  (w_fire),
        .o_byte  (w_byte)
    );

    bcp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (w_byte),
        .o_res   (w_res)
    );

    bcp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_res   (w_res),
        .o_space (w_space),
        .o_valid (o_cmd.valid),
        .i_ready (o_cmd.ready),
        .o_cmd   (w_cmd)
    );

    assign o_cmd.target = w_cmd.target;
    assign o_cmd.value  = w_cmd.value;

endmodule
